// ===== hdl/assert_macros.svh =====
// Assertion macros used by the decoder top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define CHD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// An implication checked in the cycle after the antecedent.
`define CHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/chd_pkg.sv =====
// Types and constants of the canonical Huffman decoder.
package chd_pkg;

    // Fixed field widths.
    localparam int OPC_W      = 2;
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int PAD_W      = 3;
    localparam int BIT_IDX_W  = 3;
    localparam int LEN_CMP_W  = 7;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_IDX_LEAD_PAD = 1'b0;

    // Input operation codes.
    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_DATA  = 2'd2
    } chd_opcode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_BIT,
        ST_CMP,
        ST_SYM,
        ST_FLUSH
    } chd_state_t;

    // Control of the per-length table.
    typedef struct packed {
        logic clear_all;
        logic rd_en;
        logic wr_en;
        logic wr_first;
    } chd_tbl_ctl_t;

endpackage

// ===== hdl/chd_if.sv =====
// Handshake channels of the decoder: command items in, result items out.
interface chd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [chd_pkg::OPC_W-1:0]     opcode;
    logic [chd_pkg::SYM_W-1:0]     entry_symbol;
    logic [chd_pkg::LEN_W-1:0]     entry_length;
    logic [chd_pkg::BYTE_W-1:0]    data_byte;

    modport source (
        output valid, opcode, entry_symbol, entry_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_symbol, entry_length, data_byte,
        output ready
    );
endinterface

interface chd_res_if;
    logic                          valid;
    logic                          ready;
    logic [chd_pkg::SYM_W-1:0]     symbol;
    logic                          error;
    logic                          last;

    modport source (
        output valid, symbol, error, last,
        input  ready
    );
    modport sink (
        input  valid, symbol, error, last,
        output ready
    );
endinterface

// ===== hdl/canonical_huffman_decoder_unit.sv =====
// Top level of the canonical Huffman decoder: sequencer, registers and ports.
//
//   channel | dir | handshake          | carries
//   cmd     | in  | valid/ready        | opcode, entry_symbol, entry_length, data_byte
//   res     | out | valid/ready        | symbol, error, last
//   apb     | in  | psel/penable/pready| lead_pad_bits at byte address 0
//
// A clear item is done in ST_IDLE; a load item reads the table in ST_IDLE, then writes
// it in ST_LOAD_WR. A data byte is accepted in ST_IDLE, then each bit takes a table read
// in ST_BIT and a range compare in ST_CMP, plus a symbol read in ST_SYM when the bit
// completes a code, or ST_BIT alone when it overruns the longest code; ST_FLUSH closes it.
// Reset empties the length table at once through its valid bits; no clearing pass.
// A result waits in a holding register, so the last one can be marked, then in the
// output register; the sequencer stalls when a new result finds both still full.
`include "assert_macros.svh"

module canonical_huffman_decoder_unit #(
    parameter int MAX_CODE_LEN  = 32,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    chd_cmd_if.sink                             cmd,
    chd_res_if.source                           res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [chd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [chd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [chd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int CW   = MAX_CODE_LEN;
    localparam int ALW  = $clog2(MAX_CODE_LEN + 1);
    localparam int SW   = $clog2(ALPHABET_SIZE);
    localparam int CNTW = $clog2(ALPHABET_SIZE + 1);
    localparam int LCW  = chd_pkg::LEN_CMP_W;
    localparam int BIW  = chd_pkg::BIT_IDX_W;

    // Control state.
    chd_pkg::chd_state_t          state_reg, state_next;
    logic [chd_pkg::PAD_W-1:0]    pad_reg, pad_next;
    logic                         first_pend_reg, first_pend_next;
    logic [CW-1:0]                next_code_reg, next_code_next;
    logic [ALW-1:0]               prev_len_reg, prev_len_next;
    logic [CNTW-1:0]              loaded_reg, loaded_next;
    logic [CW-1:0]                acc_reg, acc_next;
    logic [ALW-1:0]               acc_len_reg, acc_len_next;
    logic [BIW-1:0]               bit_idx_reg, bit_idx_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic                         out_valid_reg, out_valid_next;

    // Payload registers.
    logic [chd_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic [chd_pkg::SYM_W-1:0]    ld_sym_reg, ld_sym_next;
    logic [chd_pkg::LEN_W-1:0]    ld_len_reg, ld_len_next;
    logic [chd_pkg::SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                         pend_err_reg, pend_err_next;
    logic [chd_pkg::SYM_W-1:0]    out_sym_reg, out_sym_next;
    logic                         out_err_reg, out_err_next;
    logic                         out_last_reg, out_last_next;

    // Table and unit connections.
    chd_pkg::chd_tbl_ctl_t        tbl_ctl;
    logic [ALW-1:0]               tbl_rd_addr;
    logic [CW-1:0]                tbl_first;
    logic [SW-1:0]                tbl_base;
    logic [CNTW-1:0]              tbl_count;
    logic                         sym_wr_en;
    logic                         sym_rd_en;
    logic [chd_pkg::SYM_W-1:0]    sym_rd_data;
    logic                         hit;
    logic [SW-1:0]                hit_index;

    // Load checks.
    logic [LCW-1:0]               ld_len_ext;
    logic [LCW-1:0]               cmd_len_ext;
    logic [LCW-1:0]               shift_amt;
    logic [ALW-1:0]               ld_len_addr;
    logic [CW-1:0]                ones_below_prev;
    logic [CW-1:0]                ld_code;
    logic                         ld_full;
    logic                         ld_bad_len;
    logic                         ld_overflow;
    logic                         ld_ok;

    // Decode step signals.
    logic                         cfg_write;
    logic                         out_free;
    logic                         res_ok;
    logic                         at_max;
    logic                         emit_req;
    logic [chd_pkg::SYM_W-1:0]    emit_sym;
    logic                         emit_err;
    logic                         advance;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[chd_pkg::REG_SEL_BIT] == chd_pkg::REG_IDX_LEAD_PAD);
    assign prdata    = (paddr[chd_pkg::REG_SEL_BIT] == chd_pkg::REG_IDX_LEAD_PAD)
                       ? chd_pkg::APB_DATA_W'(pad_reg) : '0;

    // Channel outputs.
    assign cmd.ready  = (state_reg == chd_pkg::ST_IDLE);
    assign res.valid  = out_valid_reg;
    assign res.symbol = out_sym_reg;
    assign res.error  = out_err_reg;
    assign res.last   = out_last_reg;

    // Canonical code of the entry being loaded, and whether it is accepted.
    // The next code fits its length unless the previous code was all ones.
    always_comb
    begin
        ld_len_ext      = LCW'(ld_len_reg);
        cmd_len_ext     = LCW'(cmd.entry_length);
        ld_len_addr     = ld_len_ext[ALW-1:0];
        shift_amt       = ld_len_ext - LCW'(prev_len_reg);
        ones_below_prev = ~({CW{1'b1}} << prev_len_reg);
        ld_full         = (loaded_reg >= CNTW'(ALPHABET_SIZE));
        ld_bad_len      = (ld_len_ext == '0) || (ld_len_ext > LCW'(MAX_CODE_LEN))
                          || (ld_len_ext < LCW'(prev_len_reg));
        ld_overflow     = (loaded_reg != '0) && (next_code_reg == ones_below_prev);
        ld_code         = (loaded_reg == '0) ? '0
                          : ((next_code_reg + CW'(1)) << shift_amt);
        ld_ok           = !ld_full && !ld_bad_len && !ld_overflow;
    end

    // Sequencer: next state and datapath controls.
    always_comb
    begin
        state_next      = state_reg;
        pad_next        = pad_reg;
        first_pend_next = first_pend_reg;
        next_code_next  = next_code_reg;
        prev_len_next   = prev_len_reg;
        loaded_next     = loaded_reg;
        acc_next        = acc_reg;
        acc_len_next    = acc_len_reg;
        bit_idx_next    = bit_idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        byte_next       = byte_reg;
        ld_sym_next     = ld_sym_reg;
        ld_len_next     = ld_len_reg;
        pend_sym_next   = pend_sym_reg;
        pend_err_next   = pend_err_reg;
        out_sym_next    = out_sym_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        tbl_ctl     = '0;
        tbl_rd_addr = '0;
        sym_wr_en   = 1'b0;
        sym_rd_en   = 1'b0;
        emit_req    = 1'b0;
        emit_sym    = '0;
        emit_err    = 1'b0;
        advance     = 1'b0;

        out_free = !out_valid_reg || res.ready;
        res_ok   = !pend_valid_reg || out_free;
        at_max   = (acc_len_reg == ALW'(MAX_CODE_LEN));

        if (cfg_write)
        begin
            pad_next = pwdata[chd_pkg::PAD_W-1:0];
        end

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            chd_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (chd_pkg::chd_opcode_t'(cmd.opcode))
                        chd_pkg::OP_CLEAR:
                        begin
                            tbl_ctl.clear_all = 1'b1;
                            next_code_next    = '0;
                            prev_len_next     = '0;
                            loaded_next       = '0;
                            acc_next          = '0;
                            acc_len_next      = '0;
                            first_pend_next   = 1'b1;
                        end
                        chd_pkg::OP_LOAD:
                        begin
                            ld_sym_next    = cmd.entry_symbol;
                            ld_len_next    = cmd.entry_length;
                            tbl_ctl.rd_en  = 1'b1;
                            tbl_rd_addr    = cmd_len_ext[ALW-1:0];
                            state_next     = chd_pkg::ST_LOAD_WR;
                        end
                        chd_pkg::OP_DATA:
                        begin
                            byte_next       = cmd.data_byte;
                            bit_idx_next    = first_pend_reg
                                              ? (BIW'(7) - BIW'(pad_reg)) : BIW'(7);
                            first_pend_next = 1'b0;
                            state_next      = chd_pkg::ST_BIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Table data for the entry's length is now registered.
            chd_pkg::ST_LOAD_WR:
            begin
                if (ld_ok)
                begin
                    tbl_ctl.wr_en    = 1'b1;
                    tbl_ctl.wr_first = (tbl_count == '0);
                    sym_wr_en        = 1'b1;
                    loaded_next      = loaded_reg + CNTW'(1);
                    next_code_next   = ld_code;
                    prev_len_next    = ld_len_addr;
                end
                state_next = chd_pkg::ST_IDLE;
            end

            // Shift in one bit, or report a code that grew too long.
            chd_pkg::ST_BIT:
            begin
                if (at_max)
                begin
                    if (res_ok)
                    begin
                        emit_req     = 1'b1;
                        emit_err     = 1'b1;
                        acc_next     = '0;
                        acc_len_next = '0;
                        advance      = 1'b1;
                    end
                end
                else
                begin
                    acc_next      = (acc_reg << 1) | CW'(byte_reg[bit_idx_reg]);
                    acc_len_next  = acc_len_reg + ALW'(1);
                    tbl_ctl.rd_en = 1'b1;
                    tbl_rd_addr   = acc_len_reg + ALW'(1);
                    state_next    = chd_pkg::ST_CMP;
                end
            end

            // Range compare against the current length.
            chd_pkg::ST_CMP:
            begin
                if (hit)
                begin
                    sym_rd_en    = 1'b1;
                    acc_next     = '0;
                    acc_len_next = '0;
                    state_next   = chd_pkg::ST_SYM;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            // Symbol read data is valid; hold it until the result can move.
            chd_pkg::ST_SYM:
            begin
                if (res_ok)
                begin
                    emit_req = 1'b1;
                    emit_sym = sym_rd_data;
                    advance  = 1'b1;
                end
            end

            // The held result is the final one of this item.
            chd_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = chd_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = pend_sym_reg;
                    out_err_next    = pend_err_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = chd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = chd_pkg::ST_IDLE;
            end
        endcase

        // A new result is held back one step so that the last one can be marked.
        if (emit_req)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = pend_sym_reg;
                out_err_next   = pend_err_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = emit_sym;
            pend_err_next   = emit_err;
        end

        // Move to the next bit of the byte, or close the item.
        if (advance)
        begin
            if (bit_idx_reg == '0)
            begin
                state_next = chd_pkg::ST_FLUSH;
            end
            else
            begin
                bit_idx_next = bit_idx_reg - BIW'(1);
                state_next   = chd_pkg::ST_BIT;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= chd_pkg::ST_IDLE;
            pad_reg        <= '0;
            first_pend_reg <= 1'b1;
            next_code_reg  <= '0;
            prev_len_reg   <= '0;
            loaded_reg     <= '0;
            acc_reg        <= '0;
            acc_len_reg    <= '0;
            bit_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pad_reg        <= pad_next;
            first_pend_reg <= first_pend_next;
            next_code_reg  <= next_code_next;
            prev_len_reg   <= prev_len_next;
            loaded_reg     <= loaded_next;
            acc_reg        <= acc_next;
            acc_len_reg    <= acc_len_next;
            bit_idx_reg    <= bit_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        ld_sym_reg   <= ld_sym_next;
        ld_len_reg   <= ld_len_next;
        pend_sym_reg <= pend_sym_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    // Per-length table.
    chd_len_table #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_len_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (tbl_ctl),
        .wr_addr       (ld_len_addr),
        .wr_first_code (ld_code),
        .wr_base       (loaded_reg[SW-1:0]),
        .wr_count      (tbl_count + CNTW'(1)),
        .rd_addr       (tbl_rd_addr),
        .rd_first_code (tbl_first),
        .rd_base       (tbl_base),
        .rd_count      (tbl_count)
    );

    // Symbols in canonical order.
    chd_sym_ram #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_sym_ram (
        .clk     (clk),
        .wr_en   (sym_wr_en),
        .wr_addr (loaded_reg[SW-1:0]),
        .wr_data (ld_sym_reg),
        .rd_en   (sym_rd_en),
        .rd_addr (hit_index),
        .rd_data (sym_rd_data)
    );

    // Shared compare unit, used once per decoded bit.
    chd_match_unit #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_match (
        .code       (acc_reg),
        .first_code (tbl_first),
        .base       (tbl_base),
        .count      (tbl_count),
        .hit        (hit),
        .index      (hit_index)
    );

    // The accumulated code never grows past the longest code.
    `CHD_ASSERT_ALWAYS(a_acc_len_bound, acc_len_reg <= ALW'(MAX_CODE_LEN), "code length overrun")
    // Every held result has left before a new item is taken.
    `CHD_ASSERT_IMPLY(a_idle_no_pend, state_reg == chd_pkg::ST_IDLE, !pend_valid_reg, "result stuck")
    // A match restarts the accumulator and goes on to the symbol read.
    `CHD_ASSERT_NEXT(a_match_restart, (state_reg == chd_pkg::ST_CMP) && hit, (acc_len_reg == '0) && (state_reg == chd_pkg::ST_SYM), "match not taken")
    // The table never holds more entries than the alphabet.
    `CHD_ASSERT_ALWAYS(a_loaded_bound, loaded_reg <= CNTW'(ALPHABET_SIZE), "table overfilled")
    // An error result carries a zero symbol.
    `CHD_ASSERT_IMPLY(a_err_sym_zero, res.valid && res.error, res.symbol == '0, "error symbol nonzero")

endmodule

// ===== hdl/chd_len_table.sv =====
// Per-length table: first code, entry count and base index, registered read.
module chd_len_table #(
    parameter int MAX_CODE_LEN  = 32,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  chd_pkg::chd_tbl_ctl_t                    ctl,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]        wr_addr,
    input  logic [MAX_CODE_LEN-1:0]                  wr_first_code,
    input  logic [$clog2(ALPHABET_SIZE)-1:0]         wr_base,
    input  logic [$clog2(ALPHABET_SIZE+1)-1:0]       wr_count,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]        rd_addr,
    output logic [MAX_CODE_LEN-1:0]                  rd_first_code,
    output logic [$clog2(ALPHABET_SIZE)-1:0]         rd_base,
    output logic [$clog2(ALPHABET_SIZE+1)-1:0]       rd_count
);

    localparam int DEPTH = MAX_CODE_LEN + 1;
    localparam int CW    = MAX_CODE_LEN;
    localparam int SW    = $clog2(ALPHABET_SIZE);
    localparam int CNTW  = $clog2(ALPHABET_SIZE + 1);

    logic [CW-1:0]   first_mem [DEPTH];
    logic [SW-1:0]   base_mem  [DEPTH];
    logic [CNTW-1:0] count_mem [DEPTH];

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             rd_valid_reg;
    logic [CW-1:0]    rd_first_reg;
    logic [SW-1:0]    rd_base_reg;
    logic [CNTW-1:0]  rd_count_reg;

    // Valid bits: a clear empties every length at once, a write marks one.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear_all)
        begin
            valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            count_mem[wr_addr] <= wr_count;
            if (ctl.wr_first)
            begin
                first_mem[wr_addr] <= wr_first_code;
                base_mem[wr_addr]  <= wr_base;
            end
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_first_reg <= first_mem[rd_addr];
            rd_base_reg  <= base_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
        end
    end

    // A length that was never loaded since the last clear counts as empty.
    assign rd_first_code = rd_first_reg;
    assign rd_base       = rd_base_reg;
    assign rd_count      = rd_valid_reg ? rd_count_reg : '0;

endmodule

// ===== hdl/chd_sym_ram.sv =====
// Symbol memory indexed by canonical order, registered read.
module chd_sym_ram #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [$clog2(ALPHABET_SIZE)-1:0]     wr_addr,
    input  logic [chd_pkg::SYM_W-1:0]            wr_data,
    input  logic                                 rd_en,
    input  logic [$clog2(ALPHABET_SIZE)-1:0]     rd_addr,
    output logic [chd_pkg::SYM_W-1:0]            rd_data
);

    logic [chd_pkg::SYM_W-1:0] sym_mem [ALPHABET_SIZE];
    logic [chd_pkg::SYM_W-1:0] rd_data_reg;

    // One write port and one read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sym_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= sym_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/chd_match_unit.sv =====
// Code match unit: range compare of the accumulated code against one length.
module chd_match_unit #(
    parameter int MAX_CODE_LEN  = 32,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic [MAX_CODE_LEN-1:0]                  code,
    input  logic [MAX_CODE_LEN-1:0]                  first_code,
    input  logic [$clog2(ALPHABET_SIZE)-1:0]         base,
    input  logic [$clog2(ALPHABET_SIZE+1)-1:0]       count,
    output logic                                     hit,
    output logic [$clog2(ALPHABET_SIZE)-1:0]         index
);

    localparam int CW   = MAX_CODE_LEN;
    localparam int SW   = $clog2(ALPHABET_SIZE);
    localparam int CNTW = $clog2(ALPHABET_SIZE + 1);
    localparam int MW   = (CW > CNTW) ? CW : CNTW;

    logic          at_or_above;
    logic [CW-1:0] offset;
    logic [MW-1:0] offset_ext;
    logic [MW-1:0] count_ext;

    // The code matches when it lies in [first, first + count).
    always_comb
    begin
        at_or_above = code >= first_code;
        offset      = code - first_code;
        offset_ext  = MW'(offset);
        count_ext   = MW'(count);
        hit         = at_or_above && (offset_ext < count_ext);
        index       = base + offset_ext[SW-1:0];
    end

endmodule

// ===== tb/huffman_stream_checker.sv =====
`timescale 1ns / 100ps
// Stream checker: predicts decoded symbols from the command items and compares results.
module huffman_stream_checker
    import chd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    chd_cmd_if                    cmd,
    chd_res_if                    res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending_count,
    output int                    symbol_count,
    output int                    error_count
);

    localparam int MAX_LEN      = 32;
    localparam int TABLE_DEPTH  = 256;
    localparam logic [APB_ADDR_W-1:0] LEAD_PAD_ADDR = APB_ADDR_W'(4 * int'(REG_IDX_LEAD_PAD));

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             error;
        logic             last;
    } decoded_t;

    // Decoded results still owed by the block, oldest first.
    decoded_t expected_q[$];

    // Predicted code table and bit decoder.
    logic [SYM_W-1:0] sym_table [TABLE_DEPTH];
    logic [63:0]      first_code [MAX_LEN+1];
    int unsigned      len_count [MAX_LEN+1];
    int unsigned      base_index [MAX_LEN+1];
    logic [63:0]      last_code;
    int unsigned      last_len;
    int unsigned      entries;
    logic [63:0]      acc_code;
    int unsigned      acc_len;
    bit               fresh_stream;
    logic [PAD_W-1:0] pad_bits;

    int fails;
    int syms;
    int errs;

    // A clear item empties the per-length counts and restarts the bit decoder.
    function automatic void clear_decoder();
        for (int i = 0; i <= MAX_LEN; i++)
        begin
            len_count[i] = 0;
        end
        last_code    = '0;
        last_len     = 0;
        entries      = 0;
        acc_code     = '0;
        acc_len      = 0;
        fresh_stream = 1'b1;
    endfunction

    // Assign the next canonical code to a loaded entry, or drop the entry.
    function automatic void load_entry(logic [SYM_W-1:0] sym, logic [LEN_W-1:0] len_in);
        int unsigned len;
        logic [63:0] code;
        len = len_in;
        if (entries >= TABLE_DEPTH)
            return;
        if (len == 0 || len > MAX_LEN || len < last_len)
            return;
        code = (entries == 0) ? 64'd0 : (last_code + 64'd1) << ((len - last_len) & 63);
        // The code must fit in its own length.
        if ((code >> len) != 0)
            return;
        if (entries != 0 && code == 0)
            return;
        if (len_count[len] == 0)
        begin
            first_code[len] = code;
            base_index[len] = entries;
        end
        len_count[len]++;
        sym_table[8'(entries)] = sym;
        entries++;
        last_code = code;
        last_len  = len;
    endfunction

    // Walk the bits of one data byte, most significant first, and queue the results.
    function automatic void decode_byte(logic [BYTE_W-1:0] data);
        decoded_t    found [8];
        int          n;
        int          top_bit;
        int unsigned next_len;
        logic [63:0] offset;
        n = 0;
        top_bit = fresh_stream ? 7 - int'(pad_bits) : 7;
        fresh_stream = 1'b0;
        for (int b = top_bit; b >= 0; b--)
        begin
            next_len = acc_len + 1;
            if (next_len > MAX_LEN)
            begin
                // Too long without a match: report an error and drop this bit.
                found[n] = '{symbol: '0, error: 1'b1, last: 1'b0};
                n++;
                acc_code = '0;
                acc_len  = 0;
            end
            else
            begin
                acc_code = {acc_code[62:0], data[b]};
                acc_len  = next_len;
                offset   = acc_code - first_code[acc_len];
                if (len_count[acc_len] != 0 && acc_code >= first_code[acc_len] &&
                    offset < len_count[acc_len])
                begin
                    found[n] = '{symbol: sym_table[8'(base_index[acc_len] + offset[31:0])],
                                 error: 1'b0, last: 1'b0};
                    n++;
                    acc_code = '0;
                    acc_len  = 0;
                end
            end
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            expected_q.push_back(found[i]);
        end
    endfunction

    // Compare one accepted result against the oldest expectation.
    function automatic void check_result();
        decoded_t want;
        if (expected_q.size() == 0)
        begin
            fails++;
            $display("%0t: unexpected result: expected none, got symbol %02h error %0b last %0b",
                     $time, res.symbol, res.error, res.last);
            return;
        end
        want = expected_q.pop_front();
        if (want.error)
            errs++;
        else
            syms++;
        if (res.symbol !== want.symbol || res.error !== want.error || res.last !== want.last)
        begin
            fails++;
            $display("%0t: result mismatch: expected symbol %02h error %0b last %0b,",
                     $time, want.symbol, want.error, want.last);
            $display("%0t:   got symbol %02h error %0b last %0b",
                     $time, res.symbol, res.error, res.last);
        end
    endfunction

    // Watch the channels and the register port at every edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                sym_table[i] = '0;
            end
            for (int i = 0; i <= MAX_LEN; i++)
            begin
                first_code[i] = '0;
                base_index[i] = 0;
            end
            clear_decoder();
            pad_bits = '0;
            expected_q.delete();
            fails = 0;
            syms  = 0;
            errs  = 0;
        end
        else
        begin
            // A result taken at this edge belongs to an item accepted earlier.
            if (res.valid && res.ready)
                check_result();
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.opcode)
                    OP_CLEAR: clear_decoder();
                    OP_LOAD:  load_entry(cmd.entry_symbol, cmd.entry_length);
                    OP_DATA:  decode_byte(cmd.data_byte);
                    default:  ;
                endcase
            end
            // Register writes take effect here; reads must return the register.
            if (psel && penable && pready && paddr == LEAD_PAD_ADDR)
            begin
                if (pwrite)
                    pad_bits = pwdata[PAD_W-1:0];
                else if (prdata !== APB_DATA_W'(pad_bits))
                begin
                    fails++;
                    $display("%0t: register read mismatch: expected %08h, got %08h",
                             $time, APB_DATA_W'(pad_bits), prdata);
                end
            end
        end
        fail_count    <= fails;
        pending_count <= expected_q.size();
        symbol_count  <= syms;
        error_count   <= errs;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, command stimulus, receiver stalls and verdict.
module testbench;
    import chd_pkg::*;

    localparam logic [APB_ADDR_W-1:0] LEAD_PAD_ADDR = APB_ADDR_W'(4 * int'(REG_IDX_LEAD_PAD));
    localparam logic [OPC_W-1:0]      OP_UNUSED     = 2'd3;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_ITEMS    = 170;
    localparam int PHASE_ITEMS     = 42;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_LEN         = 32;
    localparam int TABLE_DEPTH     = 256;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_MOSTLY_ON,
        RX_MOSTLY_OFF
    } rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending_count;
    int symbol_count;
    int error_count;
    int items_sent;
    int pad_settings;
    int burst_left;
    int cycles;
    bit hold_off_request;

    // Code space used so far by the table being loaded, to keep loads well formed.
    int unsigned gen_entries;
    int unsigned gen_len;
    logic [63:0] gen_code;

    chd_cmd_if cmd_ch();
    chd_res_if res_ch();

    canonical_huffman_decoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    huffman_stream_checker stream_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .res           (res_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .symbol_count  (symbol_count),
        .error_count   (error_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a run that has not finished by the limit fails.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver: stalls on a changing pattern, with one long hold-off.
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        res_ch.ready <= 1'b0;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    RX_FREE:      res_ch.ready <= 1'b1;
                    RX_COIN:      res_ch.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY_ON: res_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:      res_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one command item in bursts with random gaps, and wait until it is taken.
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 4) == 0)
                gap = $urandom_range(7, 25);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= op;
        cmd_ch.entry_symbol <= sym;
        cmd_ch.entry_length <= len;
        cmd_ch.data_byte    <= data;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        burst_left--;
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic do_clear();
        gen_entries = 0;
        gen_len     = 0;
        gen_code    = '0;
        send_item(OP_CLEAR, rand_byte(), LEN_W'($urandom_range(0, 63)), rand_byte());
    endtask

    task automatic do_data(input logic [BYTE_W-1:0] data);
        send_item(OP_DATA, rand_byte(), LEN_W'($urandom_range(0, 63)), data);
    endtask

    // No length at or above the current one can take a code any more.
    function automatic bit table_full();
        return gen_entries >= TABLE_DEPTH ||
               (gen_entries > 0 && ((gen_code + 64'd1) >> gen_len) != 0);
    endfunction

    // Load an entry, following the code the block would give it.
    task automatic load_tracked(input logic [SYM_W-1:0] sym, input int unsigned len);
        logic [63:0] code;
        code = (gen_entries == 0) ? 64'd0 : (gen_code + 64'd1) << ((len - gen_len) & 63);
        if (gen_entries < TABLE_DEPTH && len >= 1 && len <= MAX_LEN && len >= gen_len &&
            (code >> len) == 0)
        begin
            gen_code = code;
            gen_len  = len;
            gen_entries++;
        end
        send_item(OP_LOAD, sym, LEN_W'(len), rand_byte());
    endtask

    // Items the block must ignore or reject.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:       send_item(OP_UNUSED, rand_byte(), LEN_W'($urandom_range(0, 63)),
                               rand_byte());
            1:       load_tracked(rand_byte(), 0);
            2:       load_tracked(rand_byte(), $urandom_range(MAX_LEN + 1, 63));
            default: load_tracked(rand_byte(), (gen_len > 1) ? gen_len - 1
                                                             : $urandom_range(MAX_LEN + 1, 63));
        endcase
    endtask

    // Lower valid, wait for every owed result, then let the block finish its last byte.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the pad register, then read it back for the checker.
    task automatic write_pad(input logic [PAD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEAD_PAD_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pad_settings++;
    endtask

    // One sequence: clear, a table of random lengths, then data bytes; noise mixed in.
    task automatic random_sequence();
        int n_entries;
        int n_bytes;
        int len;
        int pick;
        do_clear();
        n_entries = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 14);
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(4, MAX_LEN) : $urandom_range(1, 4);
        for (int i = 0; i < n_entries; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            if (table_full())
            begin
                // Occasionally try to oversubscribe the full table.
                if ($urandom_range(0, 1) == 0)
                    load_tracked(rand_byte(), gen_len);
                break;
            end
            load_tracked(rand_byte(), len);
            if ($urandom_range(0, 3) == 0 && len < MAX_LEN)
                len = (len + $urandom_range(1, 3) > MAX_LEN) ? MAX_LEN : len + $urandom_range(1, 3);
        end
        n_bytes = $urandom_range(2, 8);
        for (int i = 0; i < n_bytes; i++)
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                do_data(8'h00);
            else if (pick == 1)
                do_data(8'hFF);
            else if (pick == 2 && !table_full())
                // Extending the table between data bytes must not disturb decoding.
                load_tracked(rand_byte(), (gen_len == 0) ? 1 : gen_len);
            else if (pick == 3)
                send_noise();
            else
                do_data(rand_byte());
        end
    endtask

    // Stimulus: directed cases, then random phases at several pad settings.
    initial
    begin
        int random_start;
        int phase;
        int phase_end;
        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.opcode       <= OP_CLEAR;
        cmd_ch.entry_symbol <= '0;
        cmd_ch.entry_length <= '0;
        cmd_ch.data_byte    <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        hold_off_request = 1'b0;
        items_sent   = 0;
        pad_settings = 0;
        burst_left   = 0;
        gen_entries  = 0;
        gen_len      = 0;
        gen_code     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_pad(3'd0);

        // Unused opcode, then an empty table running into the length limit.
        send_item(OP_UNUSED, 8'hFF, 6'h3F, 8'hFF);
        repeat (5) do_data(8'hFF);
        do_clear();
        load_tracked(8'hA5, 1);
        load_tracked(8'h5A, 2);
        load_tracked(8'hFF, 3);
        load_tracked(8'h00, 3);
        // Rejected loads: zero length, too long, shrinking length, no code space left.
        load_tracked(8'h11, 0);
        load_tracked(8'h22, MAX_LEN + 1);
        load_tracked(8'h33, 63);
        load_tracked(8'h44, 2);
        load_tracked(8'h55, 3);
        // All zero bits give eight results from one byte.
        do_data(8'h00);
        do_data(8'hFF);
        do_data(8'h6D);
        // Codes of the greatest length.
        do_clear();
        load_tracked(8'h7E, MAX_LEN);
        load_tracked(8'h81, MAX_LEN);
        repeat (4) do_data(8'h00);

        // Widest pad: only the lowest bit of the first byte counts.
        wait_idle();
        write_pad(3'd7);
        do_clear();
        load_tracked(8'h3C, 1);
        load_tracked(8'hC3, 1);
        do_data(8'h01);
        do_data(8'h80);

        // Random phases, each at its own pad setting.
        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            wait_idle();
            write_pad((phase == 0) ? 3'd7 : (phase == 1) ? 3'd0 : 3'($urandom_range(0, 7)));
            // The receiver holds off once while the sender keeps going.
            if (phase == 1)
                hold_off_request = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                random_sequence();
            end
            phase++;
        end

        wait_idle();
        $display("Covered %0d command items over %0d pad settings.", items_sent, pad_settings);
        $display("Checked %0d decoded symbols and %0d decode errors.", symbol_count, error_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== canonical_huffman_decoder_unit.f =====
+incdir+hdl
hdl/chd_pkg.sv
hdl/chd_if.sv
hdl/chd_len_table.sv
hdl/chd_sym_ram.sv
hdl/chd_match_unit.sv
hdl/canonical_huffman_decoder_unit.sv
tb/huffman_stream_checker.sv
tb/testbench.sv
